/* rtl/core/cpts_pkg.sv */
// Shared types and constants of the counter-priority task scheduler.
package cpts_pkg;

    // Table geometry
    localparam int TASK_SLOTS = 64;
    localparam int IDX_W      = $clog2(TASK_SLOTS);
    localparam int WALK_W     = IDX_W + 1;

    // Fixed field widths
    localparam int FUNC_W  = 2;
    localparam int SLOT_W  = 6;
    localparam int COUNT_W = 9;
    localparam int PRIO_W  = 8;

    // Transaction kinds
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SCHED = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_STATE = 2'd3;

    // Reset contents of slot 0
    localparam logic [COUNT_W-1:0] BOOT_COUNT = 9'd15;
    localparam logic [PRIO_W-1:0]  BOOT_PRIO  = 8'd15;

    typedef struct packed {
        logic               valid;
        logic               runnable;
        logic [COUNT_W-1:0] counter;
        logic [PRIO_W-1:0]  prio;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } tbl_wr_t;

    typedef struct packed {
        logic               done;
        logic [SLOT_W-1:0]  current_slot;
        logic               switched;
        logic               refilled;
        logic               idle_fallback;
        logic [COUNT_W-1:0] current_count;
    } result_t;

endpackage

/* rtl/core/cpts_table.sv */
// Task table: one write port, one registered read port, per-slot written bits.
module cpts_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [cpts_pkg::IDX_W-1:0]  rd_addr,
    output cpts_pkg::entry_t            rd_data,
    input  cpts_pkg::tbl_wr_t           wr
);
    import cpts_pkg::*;

    entry_t                 mem_reg [TASK_SLOTS];
    entry_t                 mem_q_reg;
    logic [TASK_SLOTS-1:0]  written_reg;
    logic                   written_q_reg;
    logic                   zero_q_reg;
    entry_t                 boot_entry;

    // Write one entry, read one entry
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_reg[wr.addr] <= wr.data;
        end
        mem_q_reg <= mem_reg[rd_addr];
    end

    // Track which entries hold written data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg   <= '0;
            written_q_reg <= 1'b0;
            zero_q_reg    <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                written_reg[wr.addr] <= 1'b1;
            end
            written_q_reg <= written_reg[rd_addr];
            zero_q_reg    <= (rd_addr == '0);
        end
    end

    // Substitute reset contents for entries never written
    always_comb
    begin
        boot_entry.valid    = 1'b1;
        boot_entry.runnable = 1'b1;
        boot_entry.counter  = BOOT_COUNT;
        boot_entry.prio     = BOOT_PRIO;
        if (written_q_reg)
        begin
            rd_data = mem_q_reg;
        end
        else if (zero_q_reg)
        begin
            rd_data = boot_entry;
        end
        else
        begin
            rd_data = '0;
        end
    end

endmodule

/* rtl/core/cpts_ctrl.sv */
// Sequencer: walks the task table one slot a cycle through one compare/add unit.
module cpts_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [cpts_pkg::FUNC_W-1:0]   func,
    input  logic                          user_mode,
    input  logic [cpts_pkg::SLOT_W-1:0]   slot,
    input  logic                          slot_valid,
    input  logic                          runnable,
    input  logic [cpts_pkg::PRIO_W-1:0]   task_priority,
    input  logic [cpts_pkg::COUNT_W-1:0]  slice_count,
    output logic [cpts_pkg::IDX_W-1:0]    rd_addr,
    input  cpts_pkg::entry_t              rd_data,
    output cpts_pkg::tbl_wr_t             wr,
    output cpts_pkg::result_t             res
);
    import cpts_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_TICK_RD  = 4'd1;
    localparam logic [3:0] ST_TICK_UPD = 4'd2;
    localparam logic [3:0] ST_LOAD_WR  = 4'd3;
    localparam logic [3:0] ST_SET_RD   = 4'd4;
    localparam logic [3:0] ST_SET_WR   = 4'd5;
    localparam logic [3:0] ST_SCAN     = 4'd6;
    localparam logic [3:0] ST_SCAN_END = 4'd7;
    localparam logic [3:0] ST_REFILL   = 4'd8;
    localparam logic [3:0] ST_REP_RD   = 4'd9;
    localparam logic [3:0] ST_REPORT   = 4'd10;

    localparam logic [WALK_W-1:0] WALK_LAST = WALK_W'(TASK_SLOTS);

    logic [3:0]          state_reg, state_next;
    logic [IDX_W-1:0]    run_reg, run_next;
    logic [WALK_W-1:0]   idx_reg, idx_next;
    logic                found_reg, found_next;
    logic [IDX_W-1:0]    best_reg, best_next;
    logic [COUNT_W-1:0]  best_cnt_reg, best_cnt_next;
    logic                switched_reg, switched_next;
    logic                refilled_reg, refilled_next;
    logic                fallback_reg, fallback_next;

    // Captured transaction fields
    logic                user_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic                valid_in_reg;
    logic                run_in_reg;
    logic [PRIO_W-1:0]   prio_reg;
    logic [COUNT_W-1:0]  count_reg;

    logic [IDX_W-1:0]    prev_idx;
    logic [IDX_W-1:0]    slot_idx;
    logic                slot_in_range;
    logic                take;
    logic [COUNT_W-1:0]  dec_count;
    logic [COUNT_W-1:0]  refill_count;

    assign busy          = (state_reg != ST_IDLE);
    assign prev_idx      = IDX_W'(idx_reg - 1'b1);
    assign slot_idx      = IDX_W'(slot_reg);
    assign slot_in_range = (int'(slot_reg) < TASK_SLOTS);

    // Shared compare and add unit
    assign take = rd_data.valid && rd_data.runnable &&
                  (!found_reg || (rd_data.counter >= best_cnt_reg));
    assign dec_count    = (rd_data.counter > COUNT_W'(1)) ?
                          COUNT_W'(rd_data.counter - 1'b1) : '0;
    assign refill_count = COUNT_W'(rd_data.counter >> 1) + COUNT_W'(rd_data.prio);

    // Capture the transaction fields
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            user_reg     <= user_mode;
            slot_reg     <= slot;
            valid_in_reg <= slot_valid;
            run_in_reg   <= runnable;
            prio_reg     <= task_priority;
            count_reg    <= slice_count;
        end
    end

    // Advance the sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            run_reg      <= '0;
            idx_reg      <= '0;
            found_reg    <= 1'b0;
            best_reg     <= '0;
            best_cnt_reg <= '0;
            switched_reg <= 1'b0;
            refilled_reg <= 1'b0;
            fallback_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            run_reg      <= run_next;
            idx_reg      <= idx_next;
            found_reg    <= found_next;
            best_reg     <= best_next;
            best_cnt_reg <= best_cnt_next;
            switched_reg <= switched_next;
            refilled_reg <= refilled_next;
            fallback_reg <= fallback_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        run_next      = run_reg;
        idx_next      = idx_reg;
        found_next    = found_reg;
        best_next     = best_reg;
        best_cnt_next = best_cnt_reg;
        switched_next = switched_reg;
        refilled_next = refilled_reg;
        fallback_next = fallback_reg;
        rd_addr       = run_reg;
        wr.en         = 1'b0;
        wr.addr       = run_reg;
        wr.data       = rd_data;
        res.done          = 1'b0;
        res.current_slot  = SLOT_W'(run_reg);
        res.switched      = switched_reg;
        res.refilled      = refilled_reg;
        res.idle_fallback = fallback_reg;
        res.current_count = rd_data.counter;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    switched_next = 1'b0;
                    refilled_next = 1'b0;
                    fallback_next = 1'b0;
                    idx_next      = '0;
                    found_next    = 1'b0;
                    case (func)
                        FUNC_TICK:  state_next = ST_TICK_RD;
                        FUNC_SCHED:
                        begin
                            switched_next = 1'b1;
                            state_next    = ST_SCAN;
                        end
                        FUNC_LOAD:  state_next = ST_LOAD_WR;
                        FUNC_STATE: state_next = ST_SET_RD;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end

            ST_TICK_RD:
            begin
                state_next = ST_TICK_UPD;
            end

            // Decrement the running slot, clamp at zero, preempt from user mode
            ST_TICK_UPD:
            begin
                wr.en           = 1'b1;
                wr.data.counter = dec_count;
                if ((rd_data.counter <= COUNT_W'(1)) && user_reg)
                begin
                    switched_next = 1'b1;
                    state_next    = ST_SCAN;
                end
                else
                begin
                    state_next = ST_REP_RD;
                end
            end

            ST_LOAD_WR:
            begin
                wr.en            = slot_in_range;
                wr.addr          = slot_idx;
                wr.data.valid    = valid_in_reg;
                wr.data.runnable = run_in_reg;
                wr.data.counter  = count_reg;
                wr.data.prio     = prio_reg;
                state_next       = ST_REP_RD;
            end

            ST_SET_RD:
            begin
                rd_addr    = slot_idx;
                state_next = ST_SET_WR;
            end

            ST_SET_WR:
            begin
                wr.en            = slot_in_range;
                wr.addr          = slot_idx;
                wr.data.runnable = run_in_reg;
                state_next       = ST_REP_RD;
            end

            // Issue slot idx, judge the slot read last cycle
            ST_SCAN:
            begin
                rd_addr = IDX_W'(idx_reg);
                if (idx_reg != '0)
                begin
                    if (take)
                    begin
                        found_next    = 1'b1;
                        best_next     = prev_idx;
                        best_cnt_next = rd_data.counter;
                    end
                end
                if (idx_reg == WALK_LAST)
                begin
                    state_next = ST_SCAN_END;
                end
                else
                begin
                    idx_next = WALK_W'(idx_reg + 1'b1);
                end
            end

            ST_SCAN_END:
            begin
                idx_next   = '0;
                found_next = 1'b0;
                if (!found_reg)
                begin
                    run_next      = '0;
                    fallback_next = 1'b1;
                    state_next    = ST_REP_RD;
                end
                else if ((best_cnt_reg == '0) && !refilled_reg)
                begin
                    refilled_next = 1'b1;
                    state_next    = ST_REFILL;
                end
                else
                begin
                    run_next   = best_reg;
                    state_next = ST_REP_RD;
                end
            end

            // Read slot idx, write back the slot read last cycle
            ST_REFILL:
            begin
                rd_addr         = IDX_W'(idx_reg);
                wr.addr         = prev_idx;
                wr.en           = (idx_reg != '0) && rd_data.valid;
                wr.data.counter = refill_count;
                if (idx_reg == WALK_LAST)
                begin
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
                else
                begin
                    idx_next = WALK_W'(idx_reg + 1'b1);
                end
            end

            ST_REP_RD:
            begin
                state_next = ST_REPORT;
            end

            ST_REPORT:
            begin
                res.done   = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/counter_priority_task_scheduler_top.sv */
// Top level of the counter-priority task scheduler: table, sequencer, result register.
//
// A transaction is taken when start is high and busy is low; its one result appears
// on the result ports for exactly one cycle with done high, and the receiver cannot
// hold it off. The task table sits in a memory with a single read port, so every
// transaction is bound by reads through that port, one slot per cycle. A load writes
// the named slot and then reports. A set-state reads the named slot, a tick without
// preemption the running slot; each writes it back and then reports. A schedule
// request walks the table once and then reports; a tick that preempts reads and
// updates the running slot before that walk. When every runnable counter is used up,
// a refill walk and a second decision walk follow. The result is shown in the cycle
// in which busy falls, and the next transaction may be started in that same cycle.
module counter_priority_task_scheduler_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [cpts_pkg::FUNC_W-1:0]   func,
    input  logic                          user_mode,
    input  logic [cpts_pkg::SLOT_W-1:0]   slot,
    input  logic                          slot_valid,
    input  logic                          runnable,
    input  logic [cpts_pkg::PRIO_W-1:0]   task_priority,
    input  logic [cpts_pkg::COUNT_W-1:0]  slice_count,
    output logic                          done,
    output logic [cpts_pkg::SLOT_W-1:0]   current_slot,
    output logic                          switched,
    output logic                          refilled,
    output logic                          idle_fallback,
    output logic [cpts_pkg::COUNT_W-1:0]  current_count
);
    import cpts_pkg::*;

    logic [IDX_W-1:0] rd_addr;
    entry_t           rd_data;
    tbl_wr_t          wr;
    result_t          res;

    logic               done_reg;
    logic [SLOT_W-1:0]  slot_out_reg;
    logic               switched_reg;
    logic               refilled_reg;
    logic               fallback_reg;
    logic [COUNT_W-1:0] count_out_reg;

    cpts_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr      (wr)
    );

    cpts_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .user_mode     (user_mode),
        .slot          (slot),
        .slot_valid    (slot_valid),
        .runnable      (runnable),
        .task_priority (task_priority),
        .slice_count   (slice_count),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .wr            (wr),
        .res           (res)
    );

    // Hold the result strobe for one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= res.done;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        if (res.done)
        begin
            slot_out_reg  <= res.current_slot;
            switched_reg  <= res.switched;
            refilled_reg  <= res.refilled;
            fallback_reg  <= res.idle_fallback;
            count_out_reg <= res.current_count;
        end
    end

    assign done          = done_reg;
    assign current_slot  = slot_out_reg;
    assign switched      = switched_reg;
    assign refilled      = refilled_reg;
    assign idle_fallback = fallback_reg;
    assign current_count = count_out_reg;

endmodule

/* test/counter_priority_task_scheduler_top_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the counter-priority task scheduler top level.
module counter_priority_task_scheduler_top_test;
    import cpts_pkg::*;

    localparam int          RANDOM_ITEMS = 730;
    localparam int          DRAIN_CYCLES = 250;
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic               user_mode;
        logic [SLOT_W-1:0]  slot;
        logic               slot_valid;
        logic               runnable;
        logic [PRIO_W-1:0]  task_priority;
        logic [COUNT_W-1:0] slice_count;
    } sched_cmd_t;

    typedef struct packed {
        logic [SLOT_W-1:0]  current_slot;
        logic               switched;
        logic               refilled;
        logic               idle_fallback;
        logic [COUNT_W-1:0] current_count;
    } sched_result_t;

    // Shadow copy of the task table; predicts and checks the outcome of each transaction
    class scheduler_shadow;
        bit                 slot_used [TASK_SLOTS];
        bit                 slot_ready[TASK_SLOTS];
        logic [COUNT_W-1:0] slice_left[TASK_SLOTS];
        logic [PRIO_W-1:0]  slot_prio [TASK_SLOTS];
        logic [IDX_W-1:0]   cur_slot;
        sched_result_t      outcomes[$];
        int                 mismatches;

        function new();
            foreach (slot_used[i])
            begin
                slot_used[i]  = 1'b0;
                slot_ready[i] = 1'b0;
                slice_left[i] = '0;
                slot_prio[i]  = '0;
            end
            slot_used[0]  = 1'b1;
            slot_ready[0] = 1'b1;
            slice_left[0] = BOOT_COUNT;
            slot_prio[0]  = BOOT_PRIO;
            cur_slot      = '0;
            mismatches    = 0;
        endfunction

        // Find the valid runnable slot with the largest counter; ties go to the higher index
        function bit find_best(output logic [IDX_W-1:0] best,
                               output logic [COUNT_W-1:0] best_cnt);
            bit found;
            found    = 1'b0;
            best     = '0;
            best_cnt = '0;
            for (int i = TASK_SLOTS - 1; i >= 0; i--)
            begin
                if (slot_used[i] && slot_ready[i] && (!found || slice_left[i] > best_cnt))
                begin
                    found    = 1'b1;
                    best     = IDX_W'(i);
                    best_cnt = slice_left[i];
                end
            end
            return found;
        endfunction

        // Pick the next slot; refill once if every runnable counter is used up
        function void decide(output bit did_refill, output bit fell_back);
            logic [IDX_W-1:0]   best;
            logic [COUNT_W-1:0] best_cnt;
            did_refill = 1'b0;
            fell_back  = 1'b0;
            if (!find_best(best, best_cnt))
            begin
                fell_back = 1'b1;
                cur_slot  = '0;
                return;
            end
            if (best_cnt == '0)
            begin
                foreach (slice_left[i])
                    if (slot_used[i])
                        slice_left[i] = (slice_left[i] >> 1) + COUNT_W'(slot_prio[i]);
                did_refill = 1'b1;
                void'(find_best(best, best_cnt));
            end
            cur_slot = best;
        endfunction

        // Apply one accepted transaction and queue the outcome it must produce
        function void note_transaction(sched_cmd_t c);
            sched_result_t r;
            bit            did_refill;
            bit            fell_back;
            r          = '0;
            did_refill = 1'b0;
            fell_back  = 1'b0;
            case (c.func)
                FUNC_TICK:
                begin
                    if (slice_left[cur_slot] > 1)
                        slice_left[cur_slot] = slice_left[cur_slot] - 1'b1;
                    else
                    begin
                        // clamp at zero, preempt only from user mode
                        slice_left[cur_slot] = '0;
                        if (c.user_mode)
                        begin
                            r.switched = 1'b1;
                            decide(did_refill, fell_back);
                        end
                    end
                end
                FUNC_SCHED:
                begin
                    r.switched = 1'b1;
                    decide(did_refill, fell_back);
                end
                FUNC_LOAD:
                begin
                    if (int'(c.slot) < TASK_SLOTS)
                    begin
                        slot_used[c.slot]  = c.slot_valid;
                        slot_ready[c.slot] = c.runnable;
                        slot_prio[c.slot]  = c.task_priority;
                        slice_left[c.slot] = c.slice_count;
                    end
                end
                FUNC_STATE:
                begin
                    if (int'(c.slot) < TASK_SLOTS)
                        slot_ready[c.slot] = c.runnable;
                end
            endcase
            r.refilled      = did_refill;
            r.idle_fallback = fell_back;
            r.current_slot  = cur_slot;
            r.current_count = slice_left[cur_slot];
            outcomes.push_back(r);
        endfunction

        function int waiting();
            return outcomes.size();
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        // Compare one result against the oldest predicted outcome
        task check_result(sched_result_t got);
            sched_result_t want;
            if (outcomes.size() == 0)
            begin
                report($sformatf("result with nothing expected (slot %0d)", got.current_slot));
                return;
            end
            want = outcomes.pop_front();
            if (got.current_slot !== want.current_slot)
                report($sformatf("current_slot got %0d want %0d",
                                 got.current_slot, want.current_slot));
            if (got.switched !== want.switched)
                report($sformatf("switched got %b want %b", got.switched, want.switched));
            if (got.refilled !== want.refilled)
                report($sformatf("refilled got %b want %b", got.refilled, want.refilled));
            if (got.idle_fallback !== want.idle_fallback)
                report($sformatf("idle_fallback got %b want %b",
                                 got.idle_fallback, want.idle_fallback));
            if (got.current_count !== want.current_count)
                report($sformatf("current_count got %0d want %0d",
                                 got.current_count, want.current_count));
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [FUNC_W-1:0]  func;
    logic               user_mode;
    logic [SLOT_W-1:0]  slot;
    logic               slot_valid;
    logic               runnable;
    logic [PRIO_W-1:0]  task_priority;
    logic [COUNT_W-1:0] slice_count;
    logic               done;
    logic [SLOT_W-1:0]  current_slot;
    logic               switched;
    logic               refilled;
    logic               idle_fallback;
    logic [COUNT_W-1:0] current_count;

    scheduler_shadow shadow;
    int unsigned     cycles = 0;

    counter_priority_task_scheduler_top DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Watch both sides of the handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                shadow.check_result({current_slot, switched, refilled,
                                     idle_fallback, current_count});
            if (start && !busy)
                shadow.note_transaction({func, user_mode, slot, slot_valid, runnable,
                                         task_priority, slice_count});
        end
    end

    function automatic sched_cmd_t cmd_of(logic [FUNC_W-1:0] f, logic u, int s, logic v,
                                          logic r, int p, int n);
        sched_cmd_t c;
        c.func          = f;
        c.user_mode     = u;
        c.slot          = SLOT_W'(s);
        c.slot_valid    = v;
        c.runnable      = r;
        c.task_priority = PRIO_W'(p);
        c.slice_count   = COUNT_W'(n);
        return c;
    endfunction

    // Random transaction biased toward a few busy slots and short slices
    function automatic sched_cmd_t random_cmd();
        sched_cmd_t  c;
        int unsigned sel;
        c.user_mode  = 1'($urandom_range(0, 1));
        c.slot_valid = ($urandom_range(0, 99) < 85);
        c.runnable   = ($urandom_range(0, 99) < 70);
        sel = $urandom_range(0, 99);
        if (sel < 40)
            c.func = FUNC_TICK;
        else if (sel < 55)
            c.func = FUNC_SCHED;
        else if (sel < 78)
            c.func = FUNC_LOAD;
        else
            c.func = FUNC_STATE;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            c.slot = SLOT_W'($urandom_range(0, 5));
        else if (sel < 85)
            c.slot = SLOT_W'($urandom_range(58, 63));
        else
            c.slot = SLOT_W'($urandom_range(0, 63));
        sel = $urandom_range(0, 99);
        if (sel < 3)
            c.task_priority = '0;
        else if (sel < 70)
            c.task_priority = PRIO_W'($urandom_range(1, 12));
        else
            c.task_priority = PRIO_W'($urandom_range(1, 255));
        sel = $urandom_range(0, 99);
        if (sel < 70)
            c.slice_count = COUNT_W'($urandom_range(0, 12));
        else if (sel < 90)
            c.slice_count = COUNT_W'($urandom_range(0, 80));
        else
            c.slice_count = COUNT_W'($urandom_range(0, 511));
        return c;
    endfunction

    // Present one transaction and hold it until the block takes it
    task automatic send_transaction(input sched_cmd_t c);
        start         <= 1'b1;
        func          <= c.func;
        user_mode     <= c.user_mode;
        slot          <= c.slot;
        slot_valid    <= c.slot_valid;
        runnable      <= c.runnable;
        task_priority <= c.task_priority;
        slice_count   <= c.slice_count;
        do @(posedge clk); while (busy);
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Drop start and hold off until every predicted outcome has come back
    task automatic wait_drained();
        start <= 1'b0;
        do
        begin
            @(posedge clk);
            #1;
        end
        while (shadow.waiting() != 0);
        @(posedge clk);
    endtask

    initial
    begin
        int burst_left;
        int sel;
        shadow        = new();
        rst_n         = 1'b0;
        start         = 1'b0;
        func          = FUNC_TICK;
        user_mode     = 1'b0;
        slot          = '0;
        slot_valid    = 1'b0;
        runnable      = 1'b0;
        task_priority = '0;
        slice_count   = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: boot slot, clamping ticks, ties, empty slots, idle fallback, zero priority
        send_transaction(cmd_of(FUNC_TICK,  1'b0, 63, 1'b1, 1'b1, 255, 511));
        send_transaction(cmd_of(FUNC_SCHED, 1'b1, 0,  1'b0, 1'b0, 0,   0));
        send_transaction(cmd_of(FUNC_LOAD,  1'b0, 0,  1'b1, 1'b1, 15,  1));
        send_transaction(cmd_of(FUNC_TICK,  1'b0, 0,  1'b0, 1'b0, 0,   0));
        send_transaction(cmd_of(FUNC_TICK,  1'b0, 0,  1'b0, 1'b0, 0,   0));
        send_transaction(cmd_of(FUNC_TICK,  1'b1, 0,  1'b0, 1'b0, 0,   0));
        send_transaction(cmd_of(FUNC_LOAD,  1'b0, 63, 1'b1, 1'b1, 255, 511));
        send_transaction(cmd_of(FUNC_LOAD,  1'b1, 62, 1'b1, 1'b1, 1,   511));
        send_transaction(cmd_of(FUNC_SCHED, 1'b0, 0,  1'b0, 1'b0, 0,   0));
        send_transaction(cmd_of(FUNC_TICK,  1'b1, 0,  1'b0, 1'b0, 0,   0));
        send_transaction(cmd_of(FUNC_STATE, 1'b0, 63, 1'b1, 1'b0, 255, 511));
        send_transaction(cmd_of(FUNC_SCHED, 1'b0, 0,  1'b0, 1'b0, 0,   0));
        send_transaction(cmd_of(FUNC_LOAD,  1'b0, 5,  1'b0, 1'b1, 200, 300));
        send_transaction(cmd_of(FUNC_STATE, 1'b0, 7,  1'b0, 1'b1, 0,   0));
        send_transaction(cmd_of(FUNC_STATE, 1'b0, 62, 1'b0, 1'b0, 0,   0));
        send_transaction(cmd_of(FUNC_STATE, 1'b0, 0,  1'b0, 1'b0, 0,   0));
        send_transaction(cmd_of(FUNC_SCHED, 1'b0, 0,  1'b0, 1'b0, 0,   0));
        send_transaction(cmd_of(FUNC_LOAD,  1'b0, 0,  1'b0, 1'b0, 15,  2));
        send_transaction(cmd_of(FUNC_TICK,  1'b1, 0,  1'b0, 1'b0, 0,   0));
        send_transaction(cmd_of(FUNC_TICK,  1'b1, 0,  1'b0, 1'b0, 0,   0));
        send_transaction(cmd_of(FUNC_LOAD,  1'b0, 10, 1'b1, 1'b1, 0,   0));
        send_transaction(cmd_of(FUNC_SCHED, 1'b0, 0,  1'b0, 1'b0, 0,   0));
        send_transaction(cmd_of(FUNC_TICK,  1'b1, 0,  1'b0, 1'b0, 0,   0));
        send_transaction(cmd_of(FUNC_LOAD,  1'b0, 0,  1'b1, 1'b1, 15,  15));

        // Random: bursts of transactions separated by gaps of random length
        burst_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2)
                wait_drained();
            if (burst_left == 0)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 50)
                    idle_cycles(0);
                else if (sel < 85)
                    idle_cycles($urandom_range(1, 6));
                else if (sel < 95)
                    idle_cycles($urandom_range(7, 40));
                else
                    idle_cycles($urandom_range(60, 230));
                burst_left = $urandom_range(1, 24);
            end
            send_transaction(random_cmd());
            burst_left--;
        end

        // Let the last outcomes arrive, then allow for stray results
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (shadow.waiting() != 0)
            shadow.report($sformatf("%0d expected results never arrived", shadow.waiting()));
        if (shadow.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* counter_priority_task_scheduler_top.f */
rtl/core/cpts_pkg.sv
rtl/core/cpts_table.sv
rtl/core/cpts_ctrl.sv
rtl/core/counter_priority_task_scheduler_top.sv
test/counter_priority_task_scheduler_top_test.sv
